// ===== rtl/pod_pkg.sv =====
`default_nettype none

package pod_pkg;

    // display commands
    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_COLOR   = 4'd1,
        CMD_DRAW    = 4'd2,
        CMD_NEWLINE = 4'd3,
        CMD_DOWN    = 4'd4,
        CMD_UP      = 4'd5,
        CMD_LEFT    = 4'd6,
        CMD_RIGHT   = 4'd7,
        CMD_HOME    = 4'd8,
        CMD_CLEAR   = 4'd9,
        CMD_DELETE  = 4'd10,
        CMD_INSERT  = 4'd11,
        CMD_LOWER   = 4'd12,
        CMD_UPPER   = 4'd13,
        CMD_BELL    = 4'd14
    } cmd_t;

    // petscii control codes
    localparam logic [7:0] PC_BELL      = 8'd7;
    localparam logic [7:0] PC_CBM_OFF   = 8'd8;
    localparam logic [7:0] PC_CBM_ON    = 8'd9;
    localparam logic [7:0] PC_LF        = 8'd10;
    localparam logic [7:0] PC_CR        = 8'd13;
    localparam logic [7:0] PC_LOWER     = 8'd14;
    localparam logic [7:0] PC_DOWN      = 8'd17;
    localparam logic [7:0] PC_RVS_ON    = 8'd18;
    localparam logic [7:0] PC_HOME      = 8'd19;
    localparam logic [7:0] PC_DELETE    = 8'd20;
    localparam logic [7:0] PC_RIGHT     = 8'd29;
    localparam logic [7:0] PC_SHIFT_CR  = 8'd141;
    localparam logic [7:0] PC_UPPER     = 8'd142;
    localparam logic [7:0] PC_UP        = 8'd145;
    localparam logic [7:0] PC_RVS_OFF   = 8'd146;
    localparam logic [7:0] PC_CLEAR     = 8'd147;
    localparam logic [7:0] PC_INSERT    = 8'd148;
    localparam logic [7:0] PC_LEFT      = 8'd157;
    localparam logic [7:0] PC_PI        = 8'd255;

    localparam logic [7:0] SC_PI        = 8'd94;

    // offset added per 32-code group, modulo 256
    localparam logic [7:0] GROUP_OFFSET [8] = '{
        8'd128, 8'd0, 8'd192, 8'd224, 8'd64, 8'd192, 8'd128, 8'd128
    };

    typedef struct packed {
        logic       hit;
        logic [3:0] index;
    } color_t;

    // petscii color code to palette index
    function automatic color_t color_lookup(input logic [7:0] c);
        color_t r;
        r.hit   = 1'b1;
        r.index = 4'd0;
        unique case (c)
            8'd144:  r.index = 4'd0;
            8'd5:    r.index = 4'd1;
            8'd28:   r.index = 4'd2;
            8'd159:  r.index = 4'd3;
            8'd156:  r.index = 4'd4;
            8'd30:   r.index = 4'd5;
            8'd31:   r.index = 4'd6;
            8'd158:  r.index = 4'd7;
            8'd129:  r.index = 4'd8;
            8'd149:  r.index = 4'd9;
            8'd150:  r.index = 4'd10;
            8'd151:  r.index = 4'd11;
            8'd152:  r.index = 4'd12;
            8'd153:  r.index = 4'd13;
            8'd154:  r.index = 4'd14;
            8'd155:  r.index = 4'd15;
            default: r.hit   = 1'b0;
        endcase
        return r;
    endfunction

    // printable byte to screen code, reverse video sets the top bit
    function automatic logic [7:0] to_screen(input logic [7:0] c, input logic rvs);
        logic [7:0] s;
        if (c == PC_PI)
        begin
            s = SC_PI;
        end
        else
        begin
            s = c + GROUP_OFFSET[c[7:5]];
        end
        s[7] = s[7] ^ rvs;
        return s;
    endfunction

    function automatic logic is_printable(input logic [7:0] c);
        return (c[7:5] != 3'd0) && (c[7:5] != 3'd4);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/petscii_output_decoder_core.sv =====
`default_nettype none

// petscii terminal output decoder: every request on the input channel carries one
// petscii byte and yields exactly one display command on the output channel
// (color with palette index, draw with screen code, cursor moves, newline, home,
// clear, insert, delete, font select, bell or none), together with the current
// shift+c= enable. the byte is decoded combinationally against the flags for reverse
// video, shift+c= enable and "carriage return just seen", and the result is held
// in an output register. one byte is taken every clock cycle; the only limit is
// the single output register, which accepts a new byte in the same cycle that
// the held result is taken. output valid rises in the cycle after an accept. a
// line feed right after a carriage return gives command none, and a carriage
// return turns reverse video off. after reset shift+c= is enabled.
module petscii_output_decoder_core
    import pod_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    // input channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_byte,

    // output channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      command,
    output logic [3:0]      color_index,
    output logic [7:0]      screen_code,
    output logic            shift_cbm_enabled
);

    // terminal flags
    logic after_return_reg, after_return_next;
    logic reverse_mode_reg, reverse_mode_next;
    logic shift_cbm_reg,    shift_cbm_next;

    // result register
    logic       out_valid_reg;
    logic [3:0] command_reg,     command_next;
    logic [3:0] color_index_reg, color_index_next;
    logic [7:0] screen_code_reg, screen_code_next;
    logic       shift_cbm_out_reg;

    logic   accept;
    color_t color;
    cmd_t   cmd;

    // the output register frees up in the same cycle it is drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign color = color_lookup(char_byte);

    // byte decode against the current flags
    always_comb
    begin
        cmd               = CMD_NONE;
        color_index_next  = 4'd0;
        screen_code_next  = 8'd0;
        after_return_next = 1'b0;
        reverse_mode_next = reverse_mode_reg;
        shift_cbm_next    = shift_cbm_reg;
        if (char_byte == PC_LF)
        begin
            // drop the line feed of a cr/lf pair
            cmd = after_return_reg ? CMD_NONE : CMD_DOWN;
        end
        else if (color.hit)
        begin
            cmd              = CMD_COLOR;
            color_index_next = color.index;
        end
        else
        begin
            unique case (char_byte)
                PC_CR, PC_SHIFT_CR:
                begin
                    cmd               = CMD_NEWLINE;
                    reverse_mode_next = 1'b0;
                    after_return_next = 1'b1;
                end
                PC_DOWN:    cmd = CMD_DOWN;
                PC_UP:      cmd = CMD_UP;
                PC_LEFT:    cmd = CMD_LEFT;
                PC_RIGHT:   cmd = CMD_RIGHT;
                PC_HOME:    cmd = CMD_HOME;
                PC_CLEAR:   cmd = CMD_CLEAR;
                PC_DELETE:  cmd = CMD_DELETE;
                PC_INSERT:  cmd = CMD_INSERT;
                PC_LOWER:   cmd = CMD_LOWER;
                PC_UPPER:   cmd = CMD_UPPER;
                PC_BELL:    cmd = CMD_BELL;
                PC_CBM_OFF: shift_cbm_next    = 1'b0;
                PC_CBM_ON:  shift_cbm_next    = 1'b1;
                PC_RVS_ON:  reverse_mode_next = 1'b1;
                PC_RVS_OFF: reverse_mode_next = 1'b0;
                default:
                begin
                    // glyphs; unassigned control codes fall through as none
                    if (is_printable(char_byte))
                    begin
                        cmd              = CMD_DRAW;
                        screen_code_next = to_screen(char_byte, reverse_mode_reg);
                    end
                end
            endcase
        end
        command_next = cmd;
    end

    // flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_return_reg <= 1'b0;
            reverse_mode_reg <= 1'b0;
            shift_cbm_reg    <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                after_return_reg <= after_return_next;
                reverse_mode_reg <= reverse_mode_next;
                shift_cbm_reg    <= shift_cbm_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            command_reg       <= command_next;
            color_index_reg   <= color_index_next;
            screen_code_reg   <= screen_code_next;
            shift_cbm_out_reg <= shift_cbm_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign command           = command_reg;
    assign color_index       = color_index_reg;
    assign screen_code       = screen_code_reg;
    assign shift_cbm_enabled = shift_cbm_out_reg;

    // a line feed right after a carriage return gives command none
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && char_byte == PC_LF && after_return_reg
        |=> out_valid && command == CMD_NONE)
        else $error("line feed after carriage return not dropped");

    // carriage return ends reverse video and marks the return
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (char_byte == PC_CR || char_byte == PC_SHIFT_CR)
        |=> !reverse_mode_reg && after_return_reg && command == CMD_NEWLINE)
        else $error("carriage return flag update wrong");

    // unused payload fields stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command != CMD_COLOR |-> color_index == 4'd0)
        else $error("color index set outside color command");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command != CMD_DRAW |-> screen_code == 8'd0)
        else $error("screen code set outside draw command");

    // reported shift+c= state follows the flag
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> shift_cbm_enabled == shift_cbm_reg)
        else $error("shift+c= output out of step with flag");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pod_pkg::*;

    // one expected display command, one per request
    typedef struct packed {
        cmd_t       command;
        logic [3:0] color;
        logic [7:0] screen;
        logic       cbm;
    } display_t;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 575;
    // the sender waits for the output side to drain at these request counts
    localparam int DRAIN_AT_A = 25;
    localparam int DRAIN_AT_B = 300;
    // no idling on either side for this many trailing requests
    localparam int CALM_TAIL = 60;

    // screen code offset per 32-code group, modulo 256
    localparam logic [7:0] OFFSET_BY_GROUP [8] = '{
        8'd128, 8'd0, 8'd192, 8'd224, 8'd64, 8'd192, 8'd128, 8'd128
    };

    // control and color codes favored by the random part
    localparam logic [7:0] CONTROL_CODES [34] = '{
        8'd3, 8'd5, PC_BELL, PC_CBM_OFF, PC_CBM_ON, PC_LF, PC_CR, PC_LOWER,
        PC_DOWN, PC_RVS_ON, PC_HOME, PC_DELETE, 8'd28, PC_RIGHT, 8'd30, 8'd31,
        8'd129, PC_SHIFT_CR, PC_UPPER, 8'd144, PC_UP, PC_RVS_OFF, PC_CLEAR,
        PC_INSERT, 8'd149, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155,
        8'd156, PC_LEFT, 8'd158
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] command;
    logic [3:0] color_index;
    logic [7:0] screen_code;
    logic       shift_cbm_enabled;

    // bytes waiting to be sent, and display commands waiting to come back
    logic [7:0] byte_q [$];
    display_t   display_q [$];

    int n_items = 0;
    int sent_count = 0;
    int taken_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // predictor copy of the decoder flags
    logic seen_cr = 1'b0;
    logic rvs_on = 1'b0;
    logic cbm_on = 1'b1;

    petscii_output_decoder_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .char_byte         (char_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .command           (command),
        .color_index       (color_index),
        .screen_code       (screen_code),
        .shift_cbm_enabled (shift_cbm_enabled)
    );

    always #5 clk = ~clk;

    // decode one byte against the predictor flags and update them
    function automatic display_t decode_petscii(input logic [7:0] c);
        display_t   r;
        logic [7:0] s;
        r.command = CMD_NONE;
        r.color   = 4'd0;
        r.screen  = 8'd0;
        if (c == PC_LF)
        begin
            // line feed right after a carriage return is swallowed
            if (!seen_cr)
            begin
                r.command = CMD_DOWN;
            end
            seen_cr = 1'b0;
        end
        else
        begin
            seen_cr = 1'b0;
            case (c)
                8'd144:      begin r.command = CMD_COLOR; r.color = 4'd0;  end
                8'd5:        begin r.command = CMD_COLOR; r.color = 4'd1;  end
                8'd28:       begin r.command = CMD_COLOR; r.color = 4'd2;  end
                8'd159:      begin r.command = CMD_COLOR; r.color = 4'd3;  end
                8'd156:      begin r.command = CMD_COLOR; r.color = 4'd4;  end
                8'd30:       begin r.command = CMD_COLOR; r.color = 4'd5;  end
                8'd31:       begin r.command = CMD_COLOR; r.color = 4'd6;  end
                8'd158:      begin r.command = CMD_COLOR; r.color = 4'd7;  end
                8'd129:      begin r.command = CMD_COLOR; r.color = 4'd8;  end
                8'd149:      begin r.command = CMD_COLOR; r.color = 4'd9;  end
                8'd150:      begin r.command = CMD_COLOR; r.color = 4'd10; end
                8'd151:      begin r.command = CMD_COLOR; r.color = 4'd11; end
                8'd152:      begin r.command = CMD_COLOR; r.color = 4'd12; end
                8'd153:      begin r.command = CMD_COLOR; r.color = 4'd13; end
                8'd154:      begin r.command = CMD_COLOR; r.color = 4'd14; end
                8'd155:      begin r.command = CMD_COLOR; r.color = 4'd15; end
                PC_CR, PC_SHIFT_CR:
                begin
                    // carriage return drops reverse video and arms the lf filter
                    r.command = CMD_NEWLINE;
                    rvs_on    = 1'b0;
                    seen_cr   = 1'b1;
                end
                PC_DOWN:     r.command = CMD_DOWN;
                PC_UP:       r.command = CMD_UP;
                PC_LEFT:     r.command = CMD_LEFT;
                PC_RIGHT:    r.command = CMD_RIGHT;
                PC_HOME:     r.command = CMD_HOME;
                PC_CLEAR:    r.command = CMD_CLEAR;
                PC_DELETE:   r.command = CMD_DELETE;
                PC_INSERT:   r.command = CMD_INSERT;
                PC_LOWER:    r.command = CMD_LOWER;
                PC_UPPER:    r.command = CMD_UPPER;
                PC_BELL:     r.command = CMD_BELL;
                PC_CBM_OFF:  cbm_on = 1'b0;
                PC_CBM_ON:   cbm_on = 1'b1;
                PC_RVS_ON:   rvs_on = 1'b1;
                PC_RVS_OFF:  rvs_on = 1'b0;
                default:
                begin
                    // printable ranges 32..127 and 160..255
                    if ((c >= 8'd32 && c <= 8'd127) || c >= 8'd160)
                    begin
                        if (c == PC_PI)
                        begin
                            s = SC_PI;
                        end
                        else
                        begin
                            s = c + OFFSET_BY_GROUP[c[7:5]];
                        end
                        if (rvs_on)
                        begin
                            s = s + 8'd128;
                        end
                        r.command = CMD_DRAW;
                        r.screen  = s;
                    end
                end
            endcase
        end
        r.cbm = cbm_on;
        return r;
    endfunction

    // idling is allowed except in every third stretch of 64 and at the tail
    function automatic logic idle_on(input int n);
        return (n < n_items - CALM_TAIL) && (((n / 64) % 3) != 1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches = mismatches + 1;
    endtask

    // a printable byte drawn evenly from 32..127 and 160..255
    function automatic logic [7:0] any_printable();
        int v;
        v = $urandom_range(191);
        return (v < 96) ? 8'(32 + v) : 8'(64 + v);
    endfunction

    // driver: predicts every accepted request, then presents the next byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            char_byte <= 8'd0;
            send_gap  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                display_q.push_back(decode_petscii(char_byte));
                sent_count = sent_count + 1;
            end
            // a request still waiting keeps valid and payload as they are
            if (!(in_valid && !in_ready))
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if ((sent_count == DRAIN_AT_A || sent_count == DRAIN_AT_B)
                         && display_q.size() != 0)
                begin
                    // hold off until every outstanding command has come back
                    in_valid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    if (idle_on(sent_count) && $urandom_range(7) == 0)
                    begin
                        send_gap <= $urandom_range(16);
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        in_valid  <= 1'b1;
                        char_byte <= byte_q.pop_front();
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted command against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        display_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (display_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected command %0d", command));
                end
                else
                begin
                    want = display_q.pop_front();
                    if (command !== want.command)
                    begin
                        report_mismatch($sformatf("result %0d command %0d, want %0d",
                                                  taken_count, command, want.command));
                    end
                    if (color_index !== want.color)
                    begin
                        report_mismatch($sformatf("result %0d color_index %0d, want %0d",
                                                  taken_count, color_index, want.color));
                    end
                    if (screen_code !== want.screen)
                    begin
                        report_mismatch($sformatf("result %0d screen_code %0d, want %0d",
                                                  taken_count, screen_code, want.screen));
                    end
                    if (shift_cbm_enabled !== want.cbm)
                    begin
                        report_mismatch($sformatf("result %0d shift_cbm_enabled %0b, want %0b",
                                                  taken_count, shift_cbm_enabled, want.cbm));
                    end
                end
                taken_count = taken_count + 1;
            end
            // random stall bursts with out_ready held low
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (idle_on(taken_count) && $urandom_range(7) == 0)
            begin
                stall_left <= $urandom_range(16);
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int run;
        // directed part: reverse video and its clearing by carriage return
        byte_q.push_back(PC_RVS_ON);
        byte_q.push_back(8'd65);
        byte_q.push_back(PC_PI);
        byte_q.push_back(PC_CR);
        // line feed swallowed after return, then a plain one moves down
        byte_q.push_back(PC_LF);
        byte_q.push_back(PC_LF);
        // unassigned codes and the shift+c= enable
        byte_q.push_back(8'd0);
        byte_q.push_back(8'd3);
        byte_q.push_back(PC_CBM_OFF);
        byte_q.push_back(8'd32);
        byte_q.push_back(PC_CBM_ON);
        // group edges and color codes
        byte_q.push_back(8'd127);
        byte_q.push_back(8'd128);
        byte_q.push_back(8'd159);
        byte_q.push_back(8'd144);
        byte_q.push_back(8'd155);
        byte_q.push_back(8'd160);
        byte_q.push_back(8'd191);
        byte_q.push_back(8'd192);
        byte_q.push_back(8'd224);
        byte_q.push_back(PC_BELL);
        byte_q.push_back(PC_LOWER);
        byte_q.push_back(PC_UPPER);
        byte_q.push_back(PC_DOWN);
        byte_q.push_back(PC_UP);

        // random part: mostly realistic terminal streams plus plain noise
        while (byte_q.size() < 25 + RANDOM_ITEMS)
        begin
            kind = $urandom_range(9);
            case (kind)
                0, 1, 2, 3:
                begin
                    byte_q.push_back(8'($urandom_range(255)));
                end
                4, 5:
                begin
                    byte_q.push_back(CONTROL_CODES[$urandom_range(33)]);
                end
                6:
                begin
                    // cr/lf pair, sometimes a second line feed
                    byte_q.push_back($urandom_range(1) ? PC_CR : PC_SHIFT_CR);
                    byte_q.push_back(PC_LF);
                    if ($urandom_range(2) == 0)
                    begin
                        byte_q.push_back(PC_LF);
                    end
                end
                7:
                begin
                    // reverse text ended by rvs off or carriage return
                    byte_q.push_back(PC_RVS_ON);
                    run = $urandom_range(1, 4);
                    repeat (run) byte_q.push_back(any_printable());
                    byte_q.push_back($urandom_range(1) ? PC_RVS_OFF : PC_CR);
                end
                8:
                begin
                    byte_q.push_back($urandom_range(1) ? PC_CBM_OFF : PC_CBM_ON);
                    byte_q.push_back(any_printable());
                end
                default:
                begin
                    run = $urandom_range(1, 3);
                    repeat (run) byte_q.push_back(any_printable());
                end
            endcase
        end
        n_items = byte_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge so the check sees settled values
        while (byte_q.size() != 0 || in_valid || display_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (display_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d commands never arrived", display_q.size()));
        end
        if (mismatches == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== petscii_output_decoder_core.f =====
rtl/pod_pkg.sv
rtl/petscii_output_decoder_core.sv
tb/testbench.sv
